// File: rtl/core/journal_log_tracker_unit_macros.svh
// Assertion macros shared by the journal log tracker RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef JOURNAL_LOG_TRACKER_UNIT_MACROS_SVH
`define JOURNAL_LOG_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked while out of reset.
`define JLT_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("journal log tracker: implication check failed");

// Next-cycle implication, checked while out of reset.
`define JLT_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("journal log tracker: next-cycle check failed");

`else

`define JLT_ASSERT_IMP(lbl, ant, cons)
`define JLT_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

// File: rtl/core/jlt_pkg.sv
// Shared types and codes for the journal log tracker.
// No dependencies; imported by the cell and the top level.
package jlt_pkg;

  localparam int unsigned BLK_W  = 24;
  localparam int unsigned SLOT_W = 5;

  // Request codes
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_NO_BEGIN = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOG_START   = 2'd0;
  localparam logic [1:0] CFG_LOG_AREA    = 2'd1;
  localparam logic [1:0] CFG_PER_OP_RSV  = 2'd2;

  localparam logic [5:0] MAX_OPEN = 6'd63;

  // Per-cell control: rotate toward the head, or load the write key
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// File: rtl/core/jlt_cell.sv
// One entry of the logged-block ring.
// Depends on jlt_pkg for the control struct and the block width.
module jlt_cell
  import jlt_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [BLK_W-1:0] shift_data_i,
  input  logic [BLK_W-1:0] load_data_i,
  output logic [BLK_W-1:0] data_o
);

  logic [BLK_W-1:0] entry_d, entry_q;

  // Load wins over the ring shift: the slot being appended holds nothing yet
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_data_i;
    end else if (ctrl_i.shift) begin
      entry_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;

endmodule

// File: rtl/core/journal_log_tracker_unit.sv
// Journal log tracker: begin/end/write bookkeeping over a ring of entry cells.
// Depends on jlt_pkg, jlt_cell and journal_log_tracker_unit_macros.svh.
//
// Usage:
//   Requests enter on the in_* valid/ready channel, one at a time; in_ready_o
//   is high whenever no request is in progress, even while a result still
//   sits in the output register. Results leave on the out_* valid/ready
//   channel through a single output register.
//   Begin, end without commit, errors and the unused code: the result is
//   registered in S_RESP, then moved to the output register once it is free.
//   Logged write: the ring of cells rotates one full turn past the compare
//   at the head cell, so the search length is fixed.
//   Commit: one result per entry, one per cycle while the receiver takes
//   them; the ring shifts one cell per emitted entry.
//   A stall on out_ready_i holds the output register and freezes the commit
//   shift; no result is dropped.
//   Reset clears the counts, the handshake state and the configuration
//   registers to their defaults; the entry cells are not cleared, since only
//   entries below the count are ever read.
//   Configuration writes on cfg_we_i take effect at once and are to be made
//   only while the block is idle.
module journal_log_tracker_unit
  import jlt_pkg::*;
#(
  parameter int unsigned LOG_ENTRIES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [BLK_W-1:0]     cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [BLK_W-1:0]     block_number_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic                 newly_added_o,
  output logic                 commit_valid_o,
  output logic [BLK_W-1:0]     home_block_o,
  output logic [BLK_W-1:0]     log_block_o,
  output logic                 last_o
);

  `include "journal_log_tracker_unit_macros.svh"

  localparam int unsigned CW = $clog2(LOG_ENTRIES + 1);
  localparam int unsigned IW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int unsigned NW = 14;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT,
    S_RESP
  } state_e;

  state_e            state_d, state_q;
  logic [CW-1:0]     count_d, count_q;
  logic [5:0]        open_d, open_q;
  logic [IW-1:0]     k_d, k_q;
  logic [BLK_W-1:0]  key_d, key_q;
  logic              found_d, found_q;
  logic [IW-1:0]     hit_d, hit_q;
  logic [2:0]        res_status_d, res_status_q;
  logic [SLOT_W-1:0] res_slot_d, res_slot_q;
  logic              res_added_d, res_added_q;

  logic [BLK_W-1:0]  start_d, start_q;
  logic [6:0]        area_d, area_q;
  logic [5:0]        rsv_d, rsv_q;

  logic              out_valid_d, out_valid_q;
  logic [2:0]        status_d, status_q;
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic              added_d, added_q;
  logic              cv_d, cv_q;
  logic [BLK_W-1:0]  home_d, home_q;
  logic [BLK_W-1:0]  lb_d, lb_q;
  logic              last_d, last_q;

  logic [BLK_W-1:0]  cell_data [LOG_ENTRIES];
  cell_ctrl_t        cell_ctrl [LOG_ENTRIES];
  logic              ring_shift;
  logic              append;

  logic              in_xfer, out_free;
  logic [NW-1:0]     need;
  logic [6:0]        limit;
  logic              in_range, match, search_end, commit_last, emit;
  logic [BLK_W-1:0]  head;

  // Ring of entry cells: cell j takes its neighbor j+1, the last takes the head
  for (genvar j = 0; j < LOG_ENTRIES; j++) begin : g_cell
    localparam int unsigned NEXT = (j + 1) % LOG_ENTRIES;
    assign cell_ctrl[j].shift = ring_shift;
    assign cell_ctrl[j].load  = append && (count_q == CW'(j));
    jlt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[j]),
      .shift_data_i (cell_data[NEXT]),
      .load_data_i  (key_q),
      .data_o       (cell_data[j])
    );
  end

  assign head     = cell_data[0];
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign need  = NW'(count_q) + NW'(open_q + 6'd1 == 6'd0 ? 7'd64 : {1'b0, open_q} + 7'd1)
               * NW'(rsv_q);
  assign limit = (area_q == 7'd0) ? 7'd0 : area_q - 7'd1;

  assign in_range    = CW'(k_q) < count_q;
  assign match       = in_range && (head == key_q);
  assign search_end  = (state_q == S_SEARCH) && (k_q == IW'(LOG_ENTRIES - 1));
  assign commit_last = (CW'(k_q) + CW'(1)) == count_q;
  assign emit        = (state_q == S_COMMIT) && out_free;

  assign ring_shift = (state_q == S_SEARCH) || emit;
  assign append     = search_end && !found_q && !match;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    open_d       = open_q;
    k_d          = k_q;
    key_d        = key_q;
    found_d      = found_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_added_d  = res_added_q;
    start_d      = start_q;
    area_d       = area_q;
    rsv_d        = rsv_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    slot_d       = slot_q;
    added_d      = added_q;
    cv_d         = cv_q;
    home_d       = home_q;
    lb_d         = lb_q;
    last_d       = last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOG_START:  start_d = cfg_data_i;
        CFG_LOG_AREA:   area_d  = cfg_data_i[6:0];
        CFG_PER_OP_RSV: rsv_d   = cfg_data_i[5:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_added_d  = 1'b0;
          state_d      = S_RESP;
          case (req_type_i)
            REQ_BEGIN: begin
              if (need > NW'(LOG_ENTRIES) || open_q >= MAX_OPEN) begin
                res_status_d = ST_WAIT;
              end else begin
                open_d = open_q + 6'd1;
              end
            end
            REQ_WRITE: begin
              if (count_q >= CW'(LOG_ENTRIES) || 7'(count_q) >= limit) begin
                res_status_d = ST_TOO_BIG;
              end else if (open_q == 6'd0) begin
                res_status_d = ST_OUTSIDE;
              end else begin
                key_d   = block_number_i;
                k_d     = '0;
                found_d = 1'b0;
                state_d = S_SEARCH;
              end
            end
            REQ_END: begin
              if (open_q == 6'd0) begin
                res_status_d = ST_NO_BEGIN;
              end else begin
                open_d = open_q - 6'd1;
                if (open_q == 6'd1 && count_q != '0) begin
                  k_d     = '0;
                  state_d = S_COMMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        // head holds entry k after k rotations; keep the first match
        if (match && !found_q) begin
          found_d = 1'b1;
          hit_d   = k_q;
        end
        k_d = k_q + IW'(1);
        if (search_end) begin
          res_status_d = ST_OK;
          if (found_q || match) begin
            res_slot_d  = SLOT_W'(found_q ? hit_q : k_q);
            res_added_d = 1'b0;
          end else begin
            res_slot_d  = SLOT_W'(count_q);
            res_added_d = 1'b1;
            count_d     = count_q + CW'(1);
          end
          state_d = S_RESP;
        end
      end

      S_COMMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          slot_d      = SLOT_W'(k_q);
          added_d     = 1'b0;
          cv_d        = 1'b1;
          home_d      = head;
          lb_d        = start_q + BLK_W'(k_q) + BLK_W'(1);
          last_d      = commit_last;
          k_d         = k_q + IW'(1);
          if (commit_last) begin
            count_d = '0;
            state_d = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_d      = res_slot_q;
          added_d     = res_added_q;
          cv_d        = 1'b0;
          home_d      = '0;
          lb_d        = '0;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      open_q       <= '0;
      k_q          <= '0;
      key_q        <= '0;
      found_q      <= 1'b0;
      hit_q        <= '0;
      res_status_q <= ST_OK;
      res_slot_q   <= '0;
      res_added_q  <= 1'b0;
      start_q      <= 24'd2;
      area_q       <= 7'd33;
      rsv_q        <= 6'd10;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      slot_q       <= '0;
      added_q      <= 1'b0;
      cv_q         <= 1'b0;
      home_q       <= '0;
      lb_q         <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      open_q       <= open_d;
      k_q          <= k_d;
      key_q        <= key_d;
      found_q      <= found_d;
      hit_q        <= hit_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_added_q  <= res_added_d;
      start_q      <= start_d;
      area_q       <= area_d;
      rsv_q        <= rsv_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      slot_q       <= slot_d;
      added_q      <= added_d;
      cv_q         <= cv_d;
      home_q       <= home_d;
      lb_q         <= lb_d;
      last_q       <= last_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign newly_added_o  = added_q;
  assign commit_valid_o = cv_q;
  assign home_block_o   = home_q;
  assign log_block_o    = lb_q;
  assign last_o         = last_q;

  // Table never holds more than the ring has cells
  `JLT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(LOG_ENTRIES))
  // Commit runs only on a non-empty table with every operation closed
  `JLT_ASSERT_IMP(a_commit_ctx, state_q == S_COMMIT, count_q != '0 && open_q == 6'd0)
  // The final commit entry empties the table and frees the request side
  `JLT_ASSERT_NEXT(a_commit_end, emit && commit_last, count_q == '0 && in_ready_o)
  // Every transfer starts work, so the request side is not ready in the cycle after it
  `JLT_ASSERT_NEXT(a_one_at_a_time, in_xfer, !in_ready_o)

endmodule

// File: tb/sv/tb_journal_log_tracker_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for journal_log_tracker_unit: directed table, then random phases.
// Depends on jlt_pkg and the journal_log_tracker_unit RTL; results are checked in order.
module tb_journal_log_tracker_unit;
  import jlt_pkg::*;

  localparam int unsigned LOG_ENTRIES    = 32;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned PHASE_ITEMS    = 24;
  localparam int unsigned DIRECTED_COUNT = 24;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic              newly_added;
    logic              commit_valid;
    logic [BLK_W-1:0]  home_block;
    logic [BLK_W-1:0]  log_block;
    logic              last;
  } journal_result_t;

  // One table row: either a register write or a request, with an optional typed answer
  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        cfg_index;
    logic [1:0]        req;
    logic [BLK_W-1:0]  value;
    logic              known;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              added;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    '{1'b0, CFG_LOG_START,  REQ_END,   24'h000000, 1'b1, ST_NO_BEGIN, 5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'h000000, 1'b1, ST_OUTSIDE,  5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'hFFFFFF, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'h000000, 1'b1, ST_OK,       5'd0, 1'b1},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'hFFFFFF, 1'b1, ST_OK,       5'd1, 1'b1},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'h000000, 1'b1, ST_WAIT,     5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'hA5A5A5, 1'b0, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_END,   24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_END,   24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_END,   24'hFFFFFF, 1'b0, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_END,   24'h000000, 1'b1, ST_NO_BEGIN, 5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_END,   24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b1, CFG_LOG_AREA,   REQ_BEGIN, 24'd2,      1'b0, ST_OK,       5'd0, 1'b0},
    '{1'b1, CFG_LOG_START,  REQ_BEGIN, 24'hFFFFFF, 1'b0, ST_OK,       5'd0, 1'b0},
    '{1'b1, CFG_PER_OP_RSV, REQ_BEGIN, 24'd32,     1'b0, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'h000000, 1'b1, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_BEGIN, 24'h000000, 1'b1, ST_WAIT,     5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'h5A5A5A, 1'b0, ST_OK,       5'd0, 1'b0},
    '{1'b0, CFG_LOG_START,  REQ_WRITE, 24'h123456, 1'b1, ST_TOO_BIG,  5'd0, 1'b0},
    // single entry commit, log block address wraps past the top of the disk
    '{1'b0, CFG_LOG_START,  REQ_END,   24'h000000, 1'b0, ST_OK,       5'd0, 1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = '0;
  logic [BLK_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       req_type_i = '0;
  logic [BLK_W-1:0] block_number_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [2:0]       status_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic             newly_added_o;
  logic             commit_valid_o;
  logic [BLK_W-1:0] home_block_o;
  logic [BLK_W-1:0] log_block_o;
  logic             last_o;

  journal_log_tracker_unit #(.LOG_ENTRIES(LOG_ENTRIES)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Journal state as the block should hold it
  logic [BLK_W-1:0] cfg_log_start = 24'd2;
  logic [6:0]       cfg_log_area  = 7'd33;
  logic [5:0]       cfg_reserve   = 6'd10;
  logic [BLK_W-1:0] logged_home [LOG_ENTRIES];
  int               entry_count = 0;
  int               open_ops = 0;

  journal_result_t  pending_results [$];
  int               mismatch_count = 0;
  int               items_sent = 0;
  int               send_idle_pct = 30;
  int               recv_idle_pct = 10;
  logic             hold_outputs = 1'b0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Work out the results of one accepted request and queue them
  function automatic void predict_request(input logic [1:0] req, input logic [BLK_W-1:0] blk);
    journal_result_t r;
    int need;
    int limit;
    int slot;
    r = '0;
    r.last = 1'b1;
    case (req)
      REQ_BEGIN: begin
        need = entry_count + (open_ops + 1) * int'(cfg_reserve);
        if (need > LOG_ENTRIES || open_ops >= int'(MAX_OPEN)) begin
          r.status = ST_WAIT;
        end else begin
          open_ops++;
          r.status = ST_OK;
        end
        pending_results.push_back(r);
      end
      REQ_WRITE: begin
        limit = (cfg_log_area == 0) ? 0 : int'(cfg_log_area) - 1;
        if (entry_count >= LOG_ENTRIES || entry_count >= limit) begin
          r.status = ST_TOO_BIG;
        end else if (open_ops == 0) begin
          r.status = ST_OUTSIDE;
        end else begin
          slot = entry_count;
          for (int k = 0; k < entry_count; k++) begin
            if (logged_home[k] == blk) begin
              slot = k;
              break;
            end
          end
          // absorb a repeated block, append a new one for pinning
          if (slot == entry_count) begin
            logged_home[slot] = blk;
            entry_count++;
            r.newly_added = 1'b1;
          end
          r.status = ST_OK;
          r.slot_index = slot[SLOT_W-1:0];
        end
        pending_results.push_back(r);
      end
      REQ_END: begin
        if (open_ops == 0) begin
          r.status = ST_NO_BEGIN;
          pending_results.push_back(r);
        end else begin
          open_ops--;
          if (open_ops != 0 || entry_count == 0) begin
            r.status = ST_OK;
            pending_results.push_back(r);
          end else begin
            for (int k = 0; k < entry_count; k++) begin
              r = '0;
              r.status = ST_OK;
              r.slot_index = k[SLOT_W-1:0];
              r.commit_valid = 1'b1;
              r.home_block = logged_home[k];
              r.log_block = cfg_log_start + BLK_W'(k) + 24'd1;
              r.last = (k == entry_count - 1);
              pending_results.push_back(r);
            end
            entry_count = 0;
          end
        end
      end
      default: begin
        r.status = ST_OK;
        pending_results.push_back(r);
      end
    endcase
  endfunction

  task automatic compare_field(input string field, input logic [BLK_W-1:0] got,
                               input logic [BLK_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
    end
  endtask

  task automatic check_result();
    journal_result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with nothing pending, status %0d home 0x%0h",
                             status_o, home_block_o));
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", BLK_W'(status_o), BLK_W'(want.status));
    compare_field("slot_index", BLK_W'(slot_index_o), BLK_W'(want.slot_index));
    compare_field("newly_added", BLK_W'(newly_added_o), BLK_W'(want.newly_added));
    compare_field("commit_valid", BLK_W'(commit_valid_o), BLK_W'(want.commit_valid));
    compare_field("home_block", home_block_o, want.home_block);
    compare_field("log_block", log_block_o, want.log_block);
    compare_field("last", BLK_W'(last_o), BLK_W'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_result();
    end
  end

  // Result side: random stall bursts, and one long hold-off on request
  always begin
    @(negedge clk_i);
    if (hold_outputs) begin
      out_ready_i = 1'b0;
      repeat (LONG_HOLD - 1) @(negedge clk_i);
      hold_outputs = 1'b0;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      out_ready_i = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_request(input logic [1:0] req, input logic [BLK_W-1:0] blk);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    req_type_i = req;
    block_number_i = blk;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(req, blk);
    items_sent++;
  endtask

  task automatic send_paced(input logic [1:0] req, input logic [BLK_W-1:0] blk);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    send_request(req, blk);
  endtask

  // Drop valid and wait until the block is idle with nothing outstanding
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || !in_ready_o);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [BLK_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    case (idx)
      CFG_LOG_START:  cfg_log_start = data;
      CFG_LOG_AREA:   cfg_log_area = data[6:0];
      CFG_PER_OP_RSV: cfg_reserve = data[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // A well-formed transaction: begins, writes drawn partly from a small pool, ends
  task automatic run_transaction();
    logic [BLK_W-1:0] pool [4];
    int n_open;
    int n_write;
    foreach (pool[k]) pool[k] = BLK_W'($urandom());
    n_open = $urandom_range(1, 3);
    n_write = $urandom_range(0, 10);
    repeat (n_open) send_paced(REQ_BEGIN, BLK_W'($urandom()));
    for (int k = 0; k < n_write; k++) begin
      send_paced(REQ_WRITE, ($urandom_range(0, 2) == 0) ? BLK_W'($urandom())
                                                        : pool[$urandom_range(0, 3)]);
    end
    repeat (n_open) send_paced(REQ_END, BLK_W'($urandom()));
  endtask

  initial begin
    directed_row_t d;
    journal_result_t typed;
    int phase_start;
    logic paused_once;
    paused_once = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int row = 0; row < DIRECTED_COUNT; row++) begin
      d = DIRECTED_ROWS[row];
      if (d.is_cfg) begin
        wait_drained();
        write_register(d.cfg_index, d.value);
      end else begin
        send_paced(d.req, d.value);
        if (d.known) begin
          // replace the computed answer with the one written in the table
          void'(pending_results.pop_back());
          typed = '0;
          typed.status = d.status;
          typed.slot_index = d.slot;
          typed.newly_added = d.added;
          typed.last = 1'b1;
          pending_results.push_back(typed);
        end
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_register(CFG_LOG_START, BLK_W'($urandom()));
          write_register(CFG_LOG_AREA, 24'd64);
          write_register(CFG_PER_OP_RSV, 24'd1);
        end
        1: begin
          write_register(CFG_LOG_START, 24'h000000);
          write_register(CFG_LOG_AREA, 24'd2);
          write_register(CFG_PER_OP_RSV, 24'd32);
        end
        2: begin
          write_register(CFG_LOG_START, 24'hFFFFF0);
          write_register(CFG_LOG_AREA, 24'd33);
          write_register(CFG_PER_OP_RSV, 24'd10);
        end
        default: begin
          write_register(CFG_LOG_START, BLK_W'($urandom()));
          write_register(CFG_LOG_AREA, BLK_W'($urandom_range(2, 64)));
          write_register(CFG_PER_OP_RSV, BLK_W'($urandom_range(1, 12)));
        end
      endcase
      if (phase == NUM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 20 * $urandom_range(0, 2);
        recv_idle_pct = 10 * $urandom_range(0, 2);
      end

      if (phase == 0) begin
        // fill the whole table, overflow once, then commit every entry
        send_paced(REQ_BEGIN, BLK_W'($urandom()));
        repeat (LOG_ENTRIES + 1) send_paced(REQ_WRITE, BLK_W'($urandom()));
        send_paced(REQ_END, BLK_W'($urandom()));
      end
      if (phase == 2) begin
        hold_outputs = 1'b1;
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (phase == 3 && !paused_once && items_sent - phase_start >= 10) begin
          wait_drained();
          paused_once = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_paced(2'($urandom_range(0, 2)), BLK_W'($urandom()));
          end
        end else begin
          run_transaction();
        end
      end
    end

    wait_drained();
    repeat (LOG_ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS journal_log_tracker_unit");
    end else begin
      $display("FAIL journal_log_tracker_unit");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("ERROR @%0t: timeout, %0d results outstanding", $time, pending_results.size());
    $display("FAIL journal_log_tracker_unit");
    $finish;
  end

endmodule
